// ----- rtl/ipc_pkg.sv -----
package ipc_pkg;

  // Default expression buffer depth
  localparam int MaxLenDefault = 64;

  // Characters with a special role
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharMul   = 8'h2A;
  localparam logic [7:0] CharDiv   = 8'h2F;
  localparam logic [7:0] CharPow   = 8'h5E;

  // Character class as seen by the converter (after paren swap)
  typedef enum logic [1:0] {
    KIND_OPERAND,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OPER
  } kind_e;

  // One classified character, front to back
  typedef struct packed {
    logic [7:0] ch;
    kind_e      kind;
    logic [1:0] prec;
    logic       last;
  } item_t;

  // Operator precedence; anything unknown binds loosest
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CharPlus, CharMinus: p = 2'd1;
      CharMul, CharDiv:    p = 2'd2;
      CharPow:             p = 2'd3;
      default:             p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/ipc_front.sv -----
module ipc_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     in_char_i,
  input  logic           in_last_i,
  output logic           push_o,
  input  logic           full_i,
  output ipc_pkg::item_t item_o
);

  logic [7:0] swapped;
  logic       is_alnum;

  // Swap parentheses for the reversed scan
  always_comb begin
    if (in_char_i == ipc_pkg::CharOpen) begin
      swapped = ipc_pkg::CharClose;
    end else if (in_char_i == ipc_pkg::CharClose) begin
      swapped = ipc_pkg::CharOpen;
    end else begin
      swapped = in_char_i;
    end
  end

  assign is_alnum = (in_char_i >= 8'h61 && in_char_i <= 8'h7A) ||
                    (in_char_i >= 8'h41 && in_char_i <= 8'h5A) ||
                    (in_char_i >= 8'h30 && in_char_i <= 8'h39);

  // Classify the character
  always_comb begin
    item_o.ch   = swapped;
    item_o.prec = ipc_pkg::prec_of(swapped);
    item_o.last = in_last_i;
    if (is_alnum) begin
      item_o.kind = ipc_pkg::KIND_OPERAND;
    end else if (swapped == ipc_pkg::CharOpen) begin
      item_o.kind = ipc_pkg::KIND_OPEN;
    end else if (swapped == ipc_pkg::CharClose) begin
      item_o.kind = ipc_pkg::KIND_CLOSE;
    end else begin
      item_o.kind = ipc_pkg::KIND_OPER;
    end
  end

  // Handshake into the queue
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

endmodule

// ----- rtl/ipc_queue.sv -----
module ipc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ipc_pkg::item_t push_item_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           stall_i,
  output ipc_pkg::item_t item_o
);

  ipc_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o & ~stall_i;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/ipc_back.sv -----
module ipc_back #(
  parameter int MaxLen = ipc_pkg::MaxLenDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_stall_o,
  input  ipc_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_char_o,
  output logic           out_last_o,
  output logic           out_empty_o,
  output logic           overflow_o
);

  localparam int CntW  = $clog2(MaxLen + 1);
  localparam int AddrW = $clog2(MaxLen);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxLen);
  localparam logic [CntW-1:0] One    = CntW'(1);
  localparam logic [CntW-1:0] Two    = CntW'(2);

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StScanRd = 4'd1;
  localparam logic [3:0] StScanEx = 4'd2;
  localparam logic [3:0] StClose  = 4'd3;
  localparam logic [3:0] StOper   = 4'd4;
  localparam logic [3:0] StRefill = 4'd5;
  localparam logic [3:0] StDrain  = 4'd6;
  localparam logic [3:0] StEmRd   = 4'd7;
  localparam logic [3:0] StEmLd   = 4'd8;
  localparam logic [3:0] StEmWait = 4'd9;

  // Memories
  ipc_pkg::item_t txt_mem [MaxLen];
  logic [7:0]     stk_mem [MaxLen];
  logic [7:0]     res_mem [MaxLen];

  ipc_pkg::item_t txt_rd_q;
  logic [7:0]     stk_rd_q, res_rd_q;

  logic [3:0]      state_q, state_d, ret_q, ret_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d, sp_q, sp_d, rc_q, rc_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      top_q, top_d;
  ipc_pkg::item_t  cur_q, cur_d;
  logic            out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic            out_empty_q, out_empty_d;
  logic [7:0]      out_char_q, out_char_d;

  logic            txt_we, stk_we, res_we;
  logic [7:0]      res_wdata;
  logic [CntW-1:0] txt_ra, stk_ra, res_ra, stk_wa;
  logic [1:0]      top_prec;
  logic            top_live, op_pops;

  assign txt_ra   = idx_q - One;
  assign stk_ra   = sp_q - Two;
  assign res_ra   = idx_q - One;
  assign stk_wa   = sp_q - One;
  assign top_prec = ipc_pkg::prec_of(top_q);
  assign top_live = (sp_q != '0) && (top_q != ipc_pkg::CharOpen);
  assign op_pops  = (cur_q.ch == ipc_pkg::CharPow) ? (top_prec >= cur_q.prec)
                                                   : (top_prec >  cur_q.prec);

  // Text store: written while loading, read during the scan
  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      txt_mem[cnt_q[AddrW-1:0]] <= q_item_i;
    end
    txt_rd_q <= txt_mem[txt_ra[AddrW-1:0]];
  end

  // Operator stack below the cached top entry
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa[AddrW-1:0]] <= top_q;
    end
    stk_rd_q <= stk_mem[stk_ra[AddrW-1:0]];
  end

  // Result store: filled in scan order, read back in reverse
  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[rc_q[AddrW-1:0]] <= res_wdata;
    end
    res_rd_q <= res_mem[res_ra[AddrW-1:0]];
  end

  // Conversion sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sp_d        = sp_q;
    rc_d        = rc_q;
    ovf_d       = ovf_q;
    top_d       = top_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    txt_we      = 1'b0;
    stk_we      = 1'b0;
    res_we      = 1'b0;
    res_wdata   = top_q;

    unique case (state_q)
      StLoad: begin
        if (q_valid_i) begin
          if (cnt_q != MaxCnt) begin
            txt_we = 1'b1;
            cnt_d  = cnt_q + One;
          end else begin
            ovf_d = 1'b1;
          end
          if (q_item_i.last) begin
            idx_d   = (cnt_q != MaxCnt) ? cnt_q + One : cnt_q;
            sp_d    = '0;
            rc_d    = '0;
            state_d = StScanRd;
          end
        end
      end
      StScanRd: begin
        if (idx_q == '0) begin
          state_d = StDrain;
        end else begin
          idx_d   = idx_q - One;
          state_d = StScanEx;
        end
      end
      StScanEx: begin
        cur_d = txt_rd_q;
        unique case (txt_rd_q.kind)
          ipc_pkg::KIND_OPERAND: begin
            res_we    = 1'b1;
            res_wdata = txt_rd_q.ch;
            rc_d      = rc_q + One;
            state_d   = StScanRd;
          end
          ipc_pkg::KIND_OPEN: begin
            stk_we  = (sp_q != '0);
            top_d   = txt_rd_q.ch;
            sp_d    = sp_q + One;
            state_d = StScanRd;
          end
          ipc_pkg::KIND_CLOSE: state_d = StClose;
          default:             state_d = StOper;
        endcase
      end
      StClose: begin
        if (top_live) begin
          res_we  = 1'b1;
          rc_d    = rc_q + One;
          sp_d    = sp_q - One;
          ret_d   = StClose;
          state_d = StRefill;
        end else if (sp_q != '0) begin
          // matching open: discard it
          sp_d    = sp_q - One;
          ret_d   = StScanRd;
          state_d = StRefill;
        end else begin
          state_d = StScanRd;
        end
      end
      StOper: begin
        if (top_live && op_pops) begin
          res_we  = 1'b1;
          rc_d    = rc_q + One;
          sp_d    = sp_q - One;
          ret_d   = StOper;
          state_d = StRefill;
        end else begin
          stk_we  = (sp_q != '0);
          top_d   = cur_q.ch;
          sp_d    = sp_q + One;
          state_d = StScanRd;
        end
      end
      StRefill: begin
        top_d   = stk_rd_q;
        state_d = ret_q;
      end
      StDrain: begin
        if (sp_q != '0) begin
          // stray open parens are dropped
          if (top_q != ipc_pkg::CharOpen) begin
            res_we = 1'b1;
            rc_d   = rc_q + One;
          end
          sp_d    = sp_q - One;
          ret_d   = StDrain;
          state_d = StRefill;
        end else if (rc_q == '0) begin
          out_valid_d = 1'b1;
          out_char_d  = 8'd0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          state_d     = StEmWait;
        end else begin
          idx_d   = rc_q;
          state_d = StEmRd;
        end
      end
      StEmRd: begin
        idx_d   = idx_q - One;
        state_d = StEmLd;
      end
      StEmLd: begin
        out_valid_d = 1'b1;
        out_char_d  = res_rd_q;
        out_last_d  = (idx_q == '0);
        out_empty_d = 1'b0;
        state_d     = StEmWait;
      end
      StEmWait: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            state_d = StEmRd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      ret_q       <= StLoad;
      cnt_q       <= '0;
      idx_q       <= '0;
      sp_q        <= '0;
      rc_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      sp_q        <= sp_d;
      rc_q        <= rc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    cur_q       <= cur_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign q_stall_o   = (state_q != StLoad);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;
  assign overflow_o  = ovf_q;

endmodule

// ----- rtl/infix_to_prefix_converter.sv -----
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// input    | in        | in_valid_i/in_stall_o | in_char_i, in_last_i
// output   | out       | out_valid_o/out_stall_i | out_char_o, out_last_o,
//          |           |                      | out_empty_o, overflow_o
//
// Loading takes one cycle per character through a two-entry queue while the
// back end loads, else input stalls once the queue is full. The scan reads
// the stored characters in reverse; each stack pop or discarded open paren
// needs a stack memory read, an operator push or lone close paren none; the
// flush pops leftovers. Emission holds while output stalls; new input waits.
// Reset is asynchronous and active low; the memories need no clearing.
module infix_to_prefix_converter #(
  parameter int MaxLen = ipc_pkg::MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic       out_empty_o,
  output logic       overflow_o
);

  ipc_pkg::item_t front_item, q_item;
  logic           push, full, q_valid, q_stall;

  // Classify incoming transactions
  ipc_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  // Decoupling queue
  ipc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (full),
    .valid_o     (q_valid),
    .stall_i     (q_stall),
    .item_o      (q_item)
  );

  // Store, convert and emit
  ipc_back #(
    .MaxLen (MaxLen)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_stall_o   (q_stall),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .out_empty_o (out_empty_o),
    .overflow_o  (overflow_o)
  );

endmodule
